### sv/uvs_pkg.sv
// Shared constants and types for the UV sphere vertex generator.
`default_nettype none
package uvs_pkg;

  localparam int DIV_W = 16;
  localparam int QUO_W = 32;
  localparam int ANG_W = 32;
  localparam int CW    = 33;
  localparam int ATAN_LEN = 32;

  localparam logic signed [CW-1:0] ONE_Q30  = 33'sh040000000;
  localparam logic signed [CW-1:0] GAIN_Q30 = 33'sh026DD3B6A;
  localparam logic [ANG_W-1:0] EIGHTH_TURN = 32'h20000000;
  localparam logic [ANG_W-1:0] HALF_TURN   = 32'h80000000;

  localparam logic [31:0] ATAN_TURN [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef enum logic [7:0] {
    REG_SEGMENTS = 8'd0,
    REG_RADIUS   = 8'd1
  } cfg_reg_t;

endpackage
`default_nettype wire

### sv/uvs_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module uvs_div (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [uvs_pkg::DIV_W-1:0] num_hi,
  input  wire logic [uvs_pkg::QUO_W-1:0] num_lo,
  input  wire logic [uvs_pkg::DIV_W-1:0] den,
  output logic      [uvs_pkg::QUO_W-1:0] quo
);
  localparam int DW = uvs_pkg::DIV_W;
  localparam int QB = uvs_pkg::QUO_W;

  logic [DW-1:0] rem  [QB+1];
  logic [QB-1:0] lo   [QB+1];
  logic [DW-1:0] dv   [QB+1];
  logic [QB-1:0] qt   [QB+1];

  assign rem[0] = num_hi;
  assign lo[0]  = num_lo;
  assign dv[0]  = den;
  assign qt[0]  = '0;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DW:0] t;
    logic        ge;
    logic [DW:0] diff;
    always_comb begin
      t    = {rem[k], lo[k][QB-1]};
      diff = t - {1'b0, dv[k]};
      ge   = (t >= {1'b0, dv[k]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
        lo[k+1]  <= {lo[k][QB-2:0], 1'b0};
        dv[k+1]  <= dv[k];
        qt[k+1]  <= {qt[k][QB-2:0], ge};
      end
    end
  end

  assign quo = qt[QB];
endmodule
`default_nettype wire

### sv/uvs_cordic.sv
// Pipelined turn-unit CORDIC giving clamped cosine and sine in Q2.30.
`default_nettype none
module uvs_cordic #(
  parameter int STEPS = 18
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic        [uvs_pkg::ANG_W-1:0] ang,
  output logic signed      [uvs_pkg::CW-1:0]    cos_o,
  output logic signed      [uvs_pkg::CW-1:0]    sin_o
);
  localparam int CW = uvs_pkg::CW;

  logic signed [CW-1:0] xs [STEPS+1];
  logic signed [CW-1:0] ys [STEPS+1];
  logic signed [CW-1:0] zs [STEPS+1];
  logic [1:0]           qd [STEPS+1];

  logic [uvs_pkg::ANG_W-1:0] shifted;
  assign shifted = ang + uvs_pkg::EIGHTH_TURN;

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= uvs_pkg::GAIN_Q30;
      ys[0] <= '0;
      zs[0] <= $signed({3'b000, shifted[29:0]}) - $signed({1'b0, uvs_pkg::EIGHTH_TURN});
      qd[0] <= shifted[31:30];
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_iter
    localparam logic signed [CW-1:0] AT = $signed({1'b0, uvs_pkg::ATAN_TURN[k]});
    logic signed [CW-1:0] dx, dy;
    assign dx = ys[k] >>> k;
    assign dy = xs[k] >>> k;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[k][CW-1]) begin
          xs[k+1] <= xs[k] - dx;
          ys[k+1] <= ys[k] + dy;
          zs[k+1] <= zs[k] - AT;
        end else begin
          xs[k+1] <= xs[k] + dx;
          ys[k+1] <= ys[k] - dy;
          zs[k+1] <= zs[k] + AT;
        end
        qd[k+1] <= qd[k];
      end
    end
  end

  logic signed [CW-1:0] xc, yc;
  always_comb begin
    xc = xs[STEPS];
    if (xs[STEPS] > uvs_pkg::ONE_Q30) xc = uvs_pkg::ONE_Q30;
    else if (xs[STEPS] < -uvs_pkg::ONE_Q30) xc = -uvs_pkg::ONE_Q30;
    yc = ys[STEPS];
    if (ys[STEPS] > uvs_pkg::ONE_Q30) yc = uvs_pkg::ONE_Q30;
    else if (ys[STEPS] < -uvs_pkg::ONE_Q30) yc = -uvs_pkg::ONE_Q30;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (qd[STEPS])
        2'd0: begin cos_o <= xc;  sin_o <= yc;  end
        2'd1: begin cos_o <= -yc; sin_o <= xc;  end
        2'd2: begin cos_o <= -xc; sin_o <= -yc; end
        default: begin cos_o <= yc; sin_o <= -xc; end
      endcase
    end
  end
endmodule
`default_nettype wire

### sv/uv_sphere_vertex_generator_unit.sv
// UV sphere vertex generator: grid point in, position and texture coordinates out.
// Pipeline: 32 divider stages, CORDIC_STEPS + 2 CORDIC stages, rounding, two multiply
// stages. Throughput: one word per cycle; the whole pipeline
// holds while the output word waits. Synchronous reset empties the pipeline and sets
// segments to 3 and radius to 1.0.
`default_nettype none
module uv_sphere_vertex_generator_unit #(
  parameter int CORDIC_STEPS = 18,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [31:0]  s_tdata,   // ring_index, segment_index
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic      [135:0] m_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v, zero pad
  output logic              m_tuser,   // out_of_range
  input  wire logic         cfg_we,
  input  wire logic [7:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata
);
  localparam int QW = uvs_pkg::QUO_W;
  localparam int CW = uvs_pkg::CW;
  localparam int SW = FRAC_BITS + 2;
  localparam int L  = QW + CORDIC_STEPS + 5;
  localparam logic signed [CW-1:0] FR_RND = 33'sd1 <<< (29 - FRAC_BITS);
  localparam logic signed [SW+34:0] HALF = (SW+35)'(1) <<< (FRAC_BITS - 1);

  logic [15:0] segments;
  logic [31:0] radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      segments <= 16'd3;
      radius   <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uvs_pkg::REG_SEGMENTS: segments <= cfg_wdata[15:0];
        uvs_pkg::REG_RADIUS:   radius   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic en;
  logic [L-1:0] vld;
  assign en       = !vld[L-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[L-2:0], s_tvalid};
  end

  // input decode
  logic [15:0] pitch, roll, rings;
  logic        oor_in, pfull_in;
  logic [31:0] du, dv;
  assign pitch    = s_tdata[15:0];
  assign roll     = s_tdata[31:16];
  assign rings    = 16'((17'(segments) + 17'd1) >> 1);
  assign oor_in   = (segments < 16'd3) || (pitch > rings) || (roll > segments);
  assign pfull_in = (pitch == rings);
  assign du       = {roll, 16'd0} + 32'(segments >> 1);
  assign dv       = {pitch, 16'd0} + 32'(rings >> 1);

  logic [QW-1:0] q_az, q_pol, q_u, q_v;

  uvs_div u_div_az (.clk, .en, .num_hi((roll == segments) ? 16'd0 : roll),
                    .num_lo('0), .den(segments), .quo(q_az));
  uvs_div u_div_pol (.clk, .en, .num_hi(pfull_in ? 16'd0 : pitch),
                     .num_lo('0), .den(rings), .quo(q_pol));
  uvs_div u_div_u (.clk, .en, .num_hi(16'd0), .num_lo(du), .den(segments), .quo(q_u));
  uvs_div u_div_v (.clk, .en, .num_hi(16'd0), .num_lo(dv), .den(rings), .quo(q_v));

  logic oor_d [QW];
  logic pf_d  [QW];
  always_ff @(posedge clk) begin
    if (en) begin
      oor_d[0] <= oor_in;
      pf_d[0]  <= pfull_in;
      for (int k = 1; k < QW; k++) begin
        oor_d[k] <= oor_d[k-1];
        pf_d[k]  <= pf_d[k-1];
      end
    end
  end

  logic [31:0] pol;
  assign pol = pf_d[QW-1] ? uvs_pkg::HALF_TURN : {1'b0, q_pol[QW-1:1]};

  logic signed [CW-1:0] caz, saz, cpol, spol;
  uvs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_az (.clk, .en, .ang(q_az),
                                                 .cos_o(caz), .sin_o(saz));
  uvs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pol (.clk, .en, .ang(pol),
                                                  .cos_o(cpol), .sin_o(spol));

  logic [16:0] tu_d  [CORDIC_STEPS+2];
  logic [16:0] tv_d  [CORDIC_STEPS+2];
  logic        oor_s [CORDIC_STEPS+2];
  always_ff @(posedge clk) begin
    if (en) begin
      tu_d[0]  <= q_u[16:0];
      tv_d[0]  <= q_v[16:0];
      oor_s[0] <= oor_d[QW-1];
      for (int k = 1; k < CORDIC_STEPS + 2; k++) begin
        tu_d[k]  <= tu_d[k-1];
        tv_d[k]  <= tv_d[k-1];
        oor_s[k] <= oor_s[k-1];
      end
    end
  end

  // rounding to FRAC_BITS
  logic signed [CW-1:0] r_caz, r_saz, r_cpol, r_spol;
  assign r_caz  = (caz + FR_RND)  >>> (30 - FRAC_BITS);
  assign r_saz  = (saz + FR_RND)  >>> (30 - FRAC_BITS);
  assign r_cpol = (cpol + FR_RND) >>> (30 - FRAC_BITS);
  assign r_spol = (spol + FR_RND) >>> (30 - FRAC_BITS);

  logic signed [SW-1:0] caz_a, saz_a, cpol_a, spol_a;
  logic [16:0] tu_a, tv_a;
  logic        oor_a;
  always_ff @(posedge clk) begin
    if (en) begin
      caz_a  <= r_caz[SW-1:0];
      saz_a  <= r_saz[SW-1:0];
      cpol_a <= r_cpol[SW-1:0];
      spol_a <= r_spol[SW-1:0];
      tu_a   <= tu_d[CORDIC_STEPS+1];
      tv_a   <= tv_d[CORDIC_STEPS+1];
      oor_a  <= oor_s[CORDIC_STEPS+1];
    end
  end

  // radius products
  logic signed [32:0]    rad_s;
  logic signed [SW+34:0] p_s, p_y;
  assign rad_s = $signed({1'b0, radius});
  assign p_s   = ((SW+35)'(rad_s) * (SW+35)'(spol_a) + HALF) >>> FRAC_BITS;
  assign p_y   = ((SW+35)'(rad_s) * (SW+35)'(cpol_a) + HALF) >>> FRAC_BITS;

  logic signed [33:0]   sr_b;
  logic signed [32:0]   y_b;
  logic signed [SW-1:0] caz_b, saz_b;
  logic [16:0] tu_b, tv_b;
  logic        oor_b;
  always_ff @(posedge clk) begin
    if (en) begin
      sr_b  <= p_s[33:0];
      y_b   <= p_y[32:0];
      caz_b <= caz_a;
      saz_b <= saz_a;
      tu_b  <= tu_a;
      tv_b  <= tv_a;
      oor_b <= oor_a;
    end
  end

  logic signed [SW+34:0] p_x, p_z;
  assign p_x = ((SW+35)'(sr_b) * (SW+35)'(caz_b) + HALF) >>> FRAC_BITS;
  assign p_z = ((SW+35)'(sr_b) * (SW+35)'(saz_b) + HALF) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      if (oor_b) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {3'b000, tv_b, tu_b, p_z[32:0], y_b, p_x[32:0]};
      end
      m_tuser <= oor_b;
    end
  end
endmodule
`default_nettype wire
